// ===== design/cle_pkg.sv =====
// shared constants, codes and types of the console line editor
`default_nettype none

package cle_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int IDX_W        = $clog2(BUFFER_BYTES);
    localparam int BYTE_W       = 8;
    localparam int CAP_W        = 9;
    localparam int LEN_W        = 6;
    localparam int CH_W         = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [CH_W-1:0] CH_ECHO = 2'd0;
    localparam logic [CH_W-1:0] CH_LINE = 2'd1;
    localparam logic [CH_W-1:0] CH_DONE = 2'd2;

    localparam logic [BYTE_W-1:0] ASCII_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] ASCII_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] ASCII_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_TILDE = 8'h7e;
    localparam logic [BYTE_W-1:0] ASCII_DEL   = 8'h7f;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_END   = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [BYTE_W-1:0] char_byte;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== design/cle_if.sv =====
// channel interfaces: received bytes, result items, capacity writes
`default_nettype none

interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel;
    logic [7:0] data;
    logic [5:0] line_length;
    logic       last;

    modport source (output valid, output channel, output data, output line_length,
                    output last, input ready);
    modport sink   (input valid, input channel, input data, input line_length,
                    input last, output ready);
endinterface

interface cle_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

`default_nettype wire

// ===== design/cle_queue.sv =====
// short command queue between the classifier and the result sequencer
`default_nettype none

module cle_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  cle_pkg::cmd_t     push_cmd,
    input  wire               pop,
    output cle_pkg::cmd_t     head,
    output cle_pkg::q_status_t status
);
    import cle_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/cle_front.sv =====
// front end: accepts console bytes, tracks line fill, issues edit commands
`default_nettype none

module cle_front (
    input  wire                clk,
    input  wire                rst_n,
    cle_rx_if.sink             rx,
    cle_cfg_if.sink            cfg,
    input  cle_pkg::q_status_t q_status,
    output logic               push,
    output cle_pkg::cmd_t      push_cmd
);
    import cle_pkg::*;

    logic [IDX_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [CAP_W-1:0]  cap_reg;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic              is_end, is_erase, is_print, dropped, line_full, over;
    logic [CAP_W-1:0]  cap;
    logic [IDX_W-1:0]  len;

    assign rx.ready  = !q_status.full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.rx_byte;

    always_comb
    begin
        is_end    = (b == ASCII_CR) || (b == ASCII_LF);
        is_erase  = (b == ASCII_BS) || (b == ASCII_DEL);
        is_print  = (b >= ASCII_SPACE) && (b <= ASCII_TILDE);
        dropped   = drop_reg && (b == ASCII_LF);
        line_full = (count_reg == IDX_W'(BUFFER_BYTES - 1));
        // zero capacity acts as one, so the line is delivered empty
        cap       = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
        over      = (CAP_W'(count_reg) >= cap);
        len       = over ? IDX_W'(cap - CAP_W'(1)) : count_reg;

        push               = 1'b0;
        push_cmd.op        = CMD_STORE;
        push_cmd.char_byte = b;
        push_cmd.idx       = count_reg;
        push_cmd.len       = len;
        count_next         = count_reg;
        drop_next          = drop_reg;

        if (accept)
        begin
            drop_next = 1'b0;
            if (!dropped)
            begin
                if (is_end)
                begin
                    push        = 1'b1;
                    push_cmd.op = CMD_END;
                    count_next  = '0;
                    drop_next   = (b == ASCII_CR);
                end
                else if (is_erase && count_reg != '0)
                begin
                    push        = 1'b1;
                    push_cmd.op = CMD_ERASE;
                    count_next  = count_reg - IDX_W'(1);
                end
                else if (is_print && !line_full)
                begin
                    push        = 1'b1;
                    push_cmd.op = CMD_STORE;
                    count_next  = count_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.out_capacity;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/cle_back.sv =====
// back end: holds the line store and sequences echo and delivery results
`default_nettype none

module cle_back (
    input  wire                clk,
    input  wire                rst_n,
    input  cle_pkg::q_status_t q_status,
    input  cle_pkg::cmd_t      head,
    output logic               pop,
    cle_res_if.source          res
);
    import cle_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SPACE = 5'b00010,
        ST_BS    = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_LOAD  = 5'b10000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic              ovalid_reg, ovalid_next;
    logic [CH_W-1:0]   och_reg, och_next;
    logic [BYTE_W-1:0] odata_reg, odata_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic              olast_reg, olast_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] line_mem [BUFFER_BYTES];

    logic              out_free, mem_we, last_byte;

    assign res.valid       = ovalid_reg;
    assign res.channel     = och_reg;
    assign res.data        = odata_reg;
    assign res.line_length = olen_reg;
    assign res.last        = olast_reg;

    assign out_free  = !ovalid_reg || res.ready;
    assign last_byte = (rd_idx_reg == len_reg - IDX_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !res.ready;
        och_next    = och_reg;
        odata_next  = odata_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        rd_idx_next = rd_idx_reg;
        len_next    = len_reg;
        pop         = 1'b0;
        mem_we      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (out_free && !q_status.empty)
                begin
                    pop         = 1'b1;
                    ovalid_next = 1'b1;
                    och_next    = CH_ECHO;
                    olen_next   = '0;
                    case (head.op)
                        CMD_STORE:
                        begin
                            mem_we     = 1'b1;
                            odata_next = head.char_byte;
                            olast_next = 1'b1;
                        end
                        CMD_ERASE:
                        begin
                            odata_next = ASCII_BS;
                            olast_next = 1'b0;
                            state_next = ST_SPACE;
                        end
                        CMD_END:
                        begin
                            och_next    = CH_DONE;
                            odata_next  = ASCII_LF;
                            olen_next   = LEN_W'(head.len);
                            olast_next  = (head.len == '0);
                            rd_idx_next = '0;
                            len_next    = head.len;
                            if (head.len != '0)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            ovalid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SPACE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    och_next    = CH_ECHO;
                    odata_next  = ASCII_SPACE;
                    olen_next   = '0;
                    olast_next  = 1'b0;
                    state_next  = ST_BS;
                end
            end
            ST_BS:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    och_next    = CH_ECHO;
                    odata_next  = ASCII_BS;
                    olen_next   = '0;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                // read address is up, the registered read lands this edge
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    och_next    = CH_LINE;
                    odata_next  = rdata_reg;
                    olen_next   = '0;
                    olast_next  = last_byte;
                    if (last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        och_reg    <= och_next;
        odata_reg  <= odata_next;
        olen_reg   <= olen_next;
        olast_reg  <= olast_next;
        rd_idx_reg <= rd_idx_next;
        len_reg    <= len_next;
    end

    // line store: one write port from stored commands, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[head.idx] <= head.char_byte;
        end
        rdata_reg <= line_mem[rd_idx_reg];
    end

endmodule

`default_nettype wire

// ===== design/console_line_editor.sv =====
// console line editor: byte intake with echo, line editing and line delivery
//
// rx carries one console byte per transaction; it is taken whenever the
// four-entry command queue has room, so a byte can be accepted every cycle.
// res carries result items: echo bytes, a completion record (newline echo with
// the delivered length) and then the delivered line bytes, each with last set
// on the final result of its input byte. cfg writes out_capacity at any time
// the block is idle; cfg.ready is always high.
// When the sequencer is idle, the first result of a byte passes through the
// command queue and then the output register before it is shown.
// A stored printable byte gives one result, an accepted erase gives three
// results, and a line end gives the record plus one result per delivered byte,
// each fetched by the registered read of the line store memory.
// Reset empties the line, clears the pending-LF flag and sets capacity to 64;
// the store itself needs no clearing and the block is ready right away.
// When res stalls the output register holds its result, the sequencer waits,
// and rx keeps taking bytes until the queue fills.
`default_nettype none

module console_line_editor (
    input  wire       clk,
    input  wire       rst_n,
    cle_rx_if.sink    rx,
    cle_res_if.source res,
    cle_cfg_if.sink   cfg
);
    import cle_pkg::*;

    logic      push, pop;
    cmd_t      push_cmd, head;
    q_status_t q_status;

    cle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .res      (res)
    );

endmodule

`default_nettype wire

// ===== design/cle_checker.sv =====
// port-level checks on the result channel of the console line editor
`default_nettype none

module cle_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       res_valid,
    input wire       res_ready,
    input wire [1:0] res_channel,
    input wire [7:0] res_data,
    input wire [5:0] res_line_length,
    input wire       res_last
);
    import cle_pkg::*;

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_done_newline: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_channel == CH_DONE |-> res_data == ASCII_LF)
        else $error("completion record without newline echo");

    a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_channel != CH_DONE |-> res_line_length == '0)
        else $error("line length outside completion record");

    // an empty line ends with its completion record
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_channel == CH_DONE && res_line_length == '0 |-> res_last)
        else $error("empty line record not marked last");

    a_channel_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_channel == CH_ECHO || res_channel == CH_LINE ||
                      res_channel == CH_DONE)
        else $error("unknown result channel");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_channel     (res.channel),
    .res_data        (res.data),
    .res_line_length (res.line_length),
    .res_last        (res.last)
);

`default_nettype wire
